/* rtl/pkcs1_v15_unpad_checker_core_macros.svh */
// assertion helpers shared by the checker
`ifndef PKCS1_V15_UNPAD_CHECKER_CORE_MACROS_SVH
`define PKCS1_V15_UNPAD_CHECKER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define P1U_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pkcs1 unpad check failed");

// next-cycle implication, sampled on clk, off during reset
`define P1U_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pkcs1 unpad check failed");

`endif

/* rtl/pkcs1u_pkg.sv */
package pkcs1u_pkg;

  // block size limits
  localparam int MAX_BLOCK_BYTES = 512;
  localparam int MIN_BLOCK_BYTES = 11;
  localparam int POS_W           = $clog2(MAX_BLOCK_BYTES + 1);

  // field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 10;
  localparam int ST_W   = 3;

  // byte values
  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] PAD_FF    = 8'hFF;

  // block types with a defined padding rule
  localparam logic [BYTE_W-1:0] BT_FF_PAD   = 8'd1;
  localparam logic [BYTE_W-1:0] BT_RAND_PAD = 8'd2;

  // saturation value of the message counter
  localparam logic [LEN_W-1:0] CNT_MAX = '1;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_SHORT    = 3'd1;
  localparam logic [ST_W-1:0] ST_HEADER   = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPAD   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOSEP    = 3'd4;
  localparam logic [ST_W-1:0] ST_TOOLONG  = 3'd5;
  localparam logic [ST_W-1:0] ST_BADTYPE  = 3'd6;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd7;

  // configuration register indexes
  localparam logic CFG_IDX_BLOCK_TYPE  = 1'b0;
  localparam logic CFG_IDX_MAX_OUT_LEN = 1'b1;

  // parser phase
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_TYPE,
    PH_PAD,
    PH_DATA,
    PH_DEAD
  } phase_t;

  // input beat
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              is_last;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              data_valid;
    logic              block_end;
    logic [ST_W-1:0]   status;
    logic [LEN_W-1:0]  data_length;
  } out_item_t;

  // configuration register values
  typedef struct packed {
    logic [BYTE_W-1:0] block_type;
    logic [LEN_W-1:0]  max_out_len;
  } cfg_t;

endpackage

/* rtl/pkcs1_v15_unpad_checker_core.sv */
// PKCS #1 v1.5 unpadding check. Feed the decrypted block one byte per beat,
// most significant byte first, with is_last on the final byte. Message bytes
// after the 00 separator come out as data beats; the last byte always gives
// a beat with block_end, the block status and the message length. Header,
// type and padding bytes give no beat. One byte is taken every cycle when the
// output side is not stalled; a byte passes through an input register and then
// a result register before its beat shows. The per-byte work is the phase,
// position and length update and a few byte compares. There
// is no start-up clearing pass. block_type and max_out_len are written through
// the cfg port and apply from the next byte on.
module pkcs1_v15_unpad_checker_core
  import pkcs1u_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [LEN_W-1:0]  cfg_wdata
);

  cfg_t      cfg_r;
  cfg_t      cfg_nxt;
  logic      item_valid;
  in_item_t  item;
  logic      can_push;
  logic      take;
  logic      has_result;
  out_item_t result;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_BLOCK_TYPE:  cfg_nxt.block_type  = cfg_wdata[BYTE_W-1:0];
        CFG_IDX_MAX_OUT_LEN: cfg_nxt.max_out_len = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_type  <= BT_RAND_PAD;
      cfg_r.max_out_len <= LEN_W'(512);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // a held byte is processed once the result register can take its beat
  assign take = item_valid && can_push;

  pkcs1u_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  pkcs1u_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .step       (take),
    .item       (item),
    .has_result (has_result),
    .result     (result)
  );

  pkcs1u_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take && has_result),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/pkcs1u_in_reg.sv */
module pkcs1u_in_reg
  import pkcs1u_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     take,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // hold while the held beat is not taken downstream
  assign in_stall   = valid_r && !take;
  assign valid_nxt  = in_stall ? valid_r : in_valid;
  assign item_valid = valid_r;
  assign item       = item_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

endmodule

/* rtl/pkcs1u_parse.sv */
module pkcs1u_parse
  import pkcs1u_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      step,
  input  in_item_t  item,
  output logic      has_result,
  output out_item_t result
);

  phase_t            phase_r;
  phase_t            phase_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic [ST_W-1:0]   err_r;
  logic [ST_W-1:0]   err_nxt;
  logic [LEN_W-1:0]  cnt_r;
  logic [LEN_W-1:0]  cnt_nxt;

  logic              emit;
  logic              type_known;
  phase_t            phase_v;
  logic [POS_W-1:0]  pos_v;
  logic [ST_W-1:0]   err_v;
  logic [LEN_W-1:0]  cnt_v;
  logic [ST_W-1:0]   status_v;

  assign type_known = (cfg.block_type == BT_FF_PAD) || (cfg.block_type == BT_RAND_PAD);

  // phase walk for one byte
  always_comb begin
    phase_v = phase_r;
    pos_v   = pos_r;
    err_v   = err_r;
    cnt_v   = cnt_r;
    emit    = 1'b0;
    if (pos_r == POS_W'(MAX_BLOCK_BYTES)) begin
      if (err_v == ST_OK) begin
        err_v = ST_OVERFLOW;
      end
    end else begin
      case (phase_r)
        PH_LEAD: begin
          if (item.in_byte != BYTE_ZERO) begin
            if (err_v == ST_OK) err_v = ST_HEADER;
            phase_v = PH_DEAD;
          end else begin
            phase_v = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (item.in_byte != cfg.block_type) begin
            if (err_v == ST_OK) err_v = ST_HEADER;
            phase_v = PH_DEAD;
          end else if (!type_known) begin
            if (err_v == ST_OK) err_v = ST_BADTYPE;
            phase_v = PH_DEAD;
          end else begin
            phase_v = PH_PAD;
          end
        end
        PH_PAD: begin
          if (item.in_byte == BYTE_ZERO) begin
            phase_v = PH_DATA;
          end else if (cfg.block_type == BT_FF_PAD && item.in_byte != PAD_FF) begin
            if (err_v == ST_OK) err_v = ST_BADPAD;
            phase_v = PH_DEAD;
          end else if (!type_known) begin
            if (err_v == ST_OK) err_v = ST_BADTYPE;
            phase_v = PH_DEAD;
          end
        end
        PH_DATA: begin
          emit = 1'b1;
          if (cnt_r != CNT_MAX) begin
            cnt_v = cnt_r + LEN_W'(1);
          end
          if (cnt_v > cfg.max_out_len) begin
            if (err_v == ST_OK) err_v = ST_TOOLONG;
          end
        end
        default: begin
        end
      endcase
      pos_v = pos_r + POS_W'(1);
    end
  end

  // end-of-block status
  always_comb begin
    if (pos_v < POS_W'(MIN_BLOCK_BYTES)) begin
      status_v = ST_SHORT;
    end else if (err_v != ST_OK) begin
      status_v = err_v;
    end else if (phase_v != PH_DATA) begin
      status_v = ST_NOSEP;
    end else begin
      status_v = ST_OK;
    end
  end

  // result beat
  always_comb begin
    has_result         = emit || item.is_last;
    result.out_byte    = emit ? item.in_byte : BYTE_ZERO;
    result.data_valid  = emit;
    result.block_end   = item.is_last;
    result.status      = item.is_last ? status_v : ST_OK;
    result.data_length = item.is_last ? cnt_v : '0;
  end

  // state update, back to start after the last byte
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    err_nxt   = err_r;
    cnt_nxt   = cnt_r;
    if (step) begin
      if (item.is_last) begin
        phase_nxt = PH_LEAD;
        pos_nxt   = '0;
        err_nxt   = ST_OK;
        cnt_nxt   = '0;
      end else begin
        phase_nxt = phase_v;
        pos_nxt   = pos_v;
        err_nxt   = err_v;
        cnt_nxt   = cnt_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      pos_r   <= '0;
      err_r   <= ST_OK;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* rtl/pkcs1u_out_reg.sv */
module pkcs1u_out_reg
  import pkcs1u_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  // free when empty or when the held beat leaves this cycle
  assign can_push  = !valid_r || !out_stall;
  assign valid_nxt = push || (valid_r && out_stall);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

endmodule

/* rtl/pkcs1u_checker.sv */
`include "pkcs1_v15_unpad_checker_core_macros.svh"

module pkcs1u_checker
  import pkcs1u_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input out_item_t         out_data
);

  // a stalled result beat stays put
  `P1U_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // every result beat carries data or closes a block
  `P1U_ASSERT_NOW(a_out_nonempty, out_valid, out_data.data_valid || out_data.block_end)

  // status and length only on the closing beat
  `P1U_ASSERT_NOW(a_mid_clean, out_valid && !out_data.block_end,
                  out_data.status == ST_OK && out_data.data_length == '0)

  // a block without separator never produced message bytes
  `P1U_ASSERT_NOW(a_nosep_len, out_valid && out_data.block_end && out_data.status == ST_NOSEP,
                  out_data.data_length == '0)

endmodule

bind pkcs1_v15_unpad_checker_core pkcs1u_checker u_pkcs1u_checker (.*);
